/* hw/rtl/svm_pkg.sv */
`timescale 1ns / 1ps
package svm_pkg;

	// Storage and position format defaults
	localparam int SAMPLE_DEPTH_DEF = 4096;
	localparam int FRAC_BITS_DEF    = 16;

	// Field widths
	localparam int SMP_W    = 16;
	localparam int LIDX_W   = 12;
	localparam int STEP_W   = 24;
	localparam int VOL_W    = 16;
	localparam int FRAMES_W = 13;
	localparam int SHIFT_W  = 2;
	localparam int VOL_FRAC = 12;

	// Configuration port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_SPEED_STEP     = 3'd0,
		REG_VOLUME         = 3'd1,
		REG_SAMPLE_FRAMES  = 3'd2,
		REG_LOOP_ENABLE    = 3'd3,
		REG_UPSAMPLE_SHIFT = 3'd4
	} reg_idx_t;

	localparam logic [STEP_W-1:0]   SPEED_STEP_RST    = 24'd65536;
	localparam logic [VOL_W-1:0]    VOLUME_RST        = 16'd4096;
	localparam logic [FRAMES_W-1:0] SAMPLE_FRAMES_RST = 13'd4096;

	// Request kinds carried on tuser
	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_START = 2'd1,
		REQ_STOP  = 2'd2,
		REQ_MIX   = 2'd3
	} req_t;

	// Saturation bounds
	localparam logic signed [SMP_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [SMP_W-1:0] SAT_MIN = -16'sh8000;

	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 40;

endpackage

/* hw/rtl/stereo_voice_mixer_unit.sv */
`timescale 1ns / 1ps
// Stereo voice mixer: one playback voice with nearest-neighbor resampling.
// Input stream (s_*): tuser carries the request kind (load, start, stop, mix);
// tdata carries the load address and frame and the frame to mix into.
// Output stream (m_*): one result item per input item, in order: the mixed
// frame for mix items (zero otherwise) and the voice active/ended flags.
// APB port: speed_step, volume, sample_frames, loop_enable, upsample_shift at
// byte addresses 0, 4, 8, 12, 16; write them only while the block is idle.
// Result path: the sample memory is read at acceptance, then scale/add/saturate
// feeds the output register.
// Throughput: one item per cycle while the receiver takes results, set by the
// single-port sample memory that takes one load write or one mix read each cycle.
// Reset clears the voice (idle, position zero) and loads register defaults;
// the sample memory is not cleared and must be loaded before it is played.
// When the receiver stalls, the output register holds its item, the item in
// the read stage waits behind it, and s_tready drops once both are full.
module stereo_voice_mixer_unit #(
	parameter int SAMPLE_DEPTH = svm_pkg::SAMPLE_DEPTH_DEF,
	parameter int FRAC_BITS    = svm_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [svm_pkg::PADDR_W-1:0]    paddr,
	input  logic [svm_pkg::PDATA_W-1:0]    pwdata,
	output logic [svm_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	// input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// load_index[11:0], load_left[27:12], load_right[43:28],
	// mix_left[59:44], mix_right[75:60], mix_add[76], zero fill
	input  logic [svm_pkg::S_TDATA_W-1:0]  s_tdata,
	// req_type[1:0]
	input  logic [1:0]                     s_tuser,
	// result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_left[15:0], out_right[31:16], voice_active[32], voice_ended[33], zero fill
	output logic [svm_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int IDX_W  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int POS_W  = IDX_W + FRAC_BITS;
	localparam int SUM_W  = ((POS_W > svm_pkg::STEP_W) ? POS_W : svm_pkg::STEP_W) + 1;
	localparam int CMP_W  = SUM_W + svm_pkg::FRAMES_W + IDX_W + 2;

	// Configuration registers
	logic [svm_pkg::STEP_W-1:0]   speed_step_q;
	logic [svm_pkg::VOL_W-1:0]    volume_q;
	logic [svm_pkg::FRAMES_W-1:0] sample_frames_q;
	logic                         loop_enable_q;
	logic [svm_pkg::SHIFT_W-1:0]  upsample_shift_q;

	logic             cfg_wr;
	svm_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = svm_pkg::reg_idx_t'(paddr[4:2]);

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_step_q     <= svm_pkg::SPEED_STEP_RST;
			volume_q         <= svm_pkg::VOLUME_RST;
			sample_frames_q  <= svm_pkg::SAMPLE_FRAMES_RST;
			loop_enable_q    <= 1'b0;
			upsample_shift_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				svm_pkg::REG_SPEED_STEP:     speed_step_q     <= pwdata[svm_pkg::STEP_W-1:0];
				svm_pkg::REG_VOLUME:         volume_q         <= pwdata[svm_pkg::VOL_W-1:0];
				svm_pkg::REG_SAMPLE_FRAMES:  sample_frames_q  <= pwdata[svm_pkg::FRAMES_W-1:0];
				svm_pkg::REG_LOOP_ENABLE:    loop_enable_q    <= pwdata[0];
				svm_pkg::REG_UPSAMPLE_SHIFT: upsample_shift_q <= pwdata[svm_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (cfg_idx)
			svm_pkg::REG_SPEED_STEP:     prdata = svm_pkg::PDATA_W'(speed_step_q);
			svm_pkg::REG_VOLUME:         prdata = svm_pkg::PDATA_W'(volume_q);
			svm_pkg::REG_SAMPLE_FRAMES:  prdata = svm_pkg::PDATA_W'(sample_frames_q);
			svm_pkg::REG_LOOP_ENABLE:    prdata = svm_pkg::PDATA_W'(loop_enable_q);
			svm_pkg::REG_UPSAMPLE_SHIFT: prdata = svm_pkg::PDATA_W'(upsample_shift_q);
			default:                     prdata = '0;
		endcase
	end

	// Unpack input item
	svm_pkg::req_t                  req_type;
	logic [svm_pkg::LIDX_W-1:0]     load_index;
	logic [svm_pkg::SMP_W-1:0]      load_left;
	logic [svm_pkg::SMP_W-1:0]      load_right;
	logic [svm_pkg::SMP_W-1:0]      mix_left;
	logic [svm_pkg::SMP_W-1:0]      mix_right;
	logic                           mix_add;

	assign req_type   = svm_pkg::req_t'(s_tuser);
	assign load_index = s_tdata[11:0];
	assign load_left  = s_tdata[27:12];
	assign load_right = s_tdata[43:28];
	assign mix_left   = s_tdata[59:44];
	assign mix_right  = s_tdata[75:60];
	assign mix_add    = s_tdata[76];

	// Handshake and pipeline control
	logic valid_s1;
	logic m_valid_q;
	logic accept;
	logic advance;

	assign advance  = valid_s1 & (~m_valid_q | m_tready);
	assign s_tready = ~valid_s1 | ~m_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	// Voice state
	logic [POS_W-1:0] pos_q;
	logic             voice_on_q;

	logic [svm_pkg::STEP_W-1:0]   step_eff;
	logic [SUM_W-1:0]             pos_sum;
	logic [svm_pkg::FRAMES_W-1:0] frames_min;
	logic [CMP_W-1:0]             frames_eff;
	logic [CMP_W-1:0]             end_mark;
	logic                         contrib;
	logic                         at_end;
	logic [POS_W-1:0]             pos_nxt;
	logic                         voice_nxt;
	logic                         ended_nxt;

	// Compute position advance and end of sound
	always_comb begin
		step_eff   = speed_step_q >> upsample_shift_q;
		pos_sum    = SUM_W'(pos_q) + SUM_W'(step_eff);
		frames_min = (sample_frames_q == '0) ? svm_pkg::FRAMES_W'(1) : sample_frames_q;
		frames_eff = (CMP_W'(frames_min) > CMP_W'(SAMPLE_DEPTH)) ?
			CMP_W'(SAMPLE_DEPTH) : CMP_W'(frames_min);
		end_mark   = frames_eff << FRAC_BITS;
		contrib    = voice_on_q & (speed_step_q != '0);
		at_end     = CMP_W'(pos_sum) >= end_mark;
		pos_nxt    = pos_q;
		voice_nxt  = voice_on_q;
		ended_nxt  = 1'b0;
		case (req_type)
			svm_pkg::REQ_START: begin
				pos_nxt   = '0;
				voice_nxt = 1'b1;
			end
			svm_pkg::REQ_STOP: begin
				voice_nxt = 1'b0;
			end
			svm_pkg::REQ_MIX: begin
				if (contrib) begin
					if (at_end) begin
						pos_nxt = '0;
						if (!loop_enable_q) begin
							voice_nxt = 1'b0;
							ended_nxt = 1'b1;
						end
					end else begin
						pos_nxt = POS_W'(pos_sum);
					end
				end
			end
			default: ;
		endcase
	end

	// Update voice state per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			voice_on_q <= 1'b0;
		end else if (accept) begin
			pos_q      <= pos_nxt;
			voice_on_q <= voice_nxt;
		end
	end

	// Sample memory: left in the low half, right in the high half
	logic [2*svm_pkg::SMP_W-1:0] sample_mem [SAMPLE_DEPTH];
	logic [2*svm_pkg::SMP_W-1:0] frame_s1;
	logic                        load_ok;
	logic [IDX_W-1:0]            wr_addr;
	logic [IDX_W-1:0]            rd_addr;

	assign load_ok = (32'(load_index) < 32'(SAMPLE_DEPTH));
	assign wr_addr = IDX_W'(load_index);
	assign rd_addr = pos_q[POS_W-1:FRAC_BITS];

	// Write on load, read the current frame on mix
	always_ff @(posedge clk) begin
		if (accept && (req_type == svm_pkg::REQ_LOAD) && load_ok) begin
			sample_mem[wr_addr] <= {load_right, load_left};
		end
		if (accept && (req_type == svm_pkg::REQ_MIX)) begin
			frame_s1 <= sample_mem[rd_addr];
		end
	end

	// Read stage registers
	logic                      is_mix_s1;
	logic                      contrib_s1;
	logic                      add_s1;
	logic [svm_pkg::SMP_W-1:0] mix_l_s1;
	logic [svm_pkg::SMP_W-1:0] mix_r_s1;
	logic                      active_s1;
	logic                      ended_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture item fields for the mix stage
	always_ff @(posedge clk) begin
		if (accept) begin
			is_mix_s1  <= (req_type == svm_pkg::REQ_MIX);
			contrib_s1 <= contrib;
			add_s1     <= mix_add;
			mix_l_s1   <= mix_left;
			mix_r_s1   <= mix_right;
			active_s1  <= voice_nxt;
			ended_s1   <= ended_nxt & (req_type == svm_pkg::REQ_MIX);
		end
	end

	// Scale, add and saturate both channels
	logic [svm_pkg::SMP_W-1:0] out_l;
	logic [svm_pkg::SMP_W-1:0] out_r;

	always_comb begin
		logic [svm_pkg::SMP_W-1:0]             smp   [2];
		logic [svm_pkg::SMP_W-1:0]             base  [2];
		logic [svm_pkg::SMP_W-1:0]             res   [2];
		logic [svm_pkg::SMP_W-1:0]             mag;
		logic [svm_pkg::SMP_W+svm_pkg::VOL_W-1:0] prod;
		logic [20:0]                           q;
		logic [20:0]                           sc;
		logic [21:0]                           acc;
		smp[0]  = frame_s1[svm_pkg::SMP_W-1:0];
		smp[1]  = frame_s1[2*svm_pkg::SMP_W-1:svm_pkg::SMP_W];
		base[0] = add_s1 ? mix_l_s1 : '0;
		base[1] = add_s1 ? mix_r_s1 : '0;
		for (int ch = 0; ch < 2; ch++) begin
			mag  = smp[ch][svm_pkg::SMP_W-1] ? (~smp[ch] + 16'd1) : smp[ch];
			prod = 32'(mag) * 32'(volume_q);
			q    = {1'b0, prod[31:svm_pkg::VOL_FRAC]};
			sc   = smp[ch][svm_pkg::SMP_W-1] ? (~q + 21'd1) : q;
			acc  = {{6{base[ch][svm_pkg::SMP_W-1]}}, base[ch]} + {sc[20], sc};
			if (!is_mix_s1) begin
				res[ch] = '0;
			end else if (!contrib_s1) begin
				res[ch] = base[ch];
			end else if ($signed(acc) > 22'sd32767) begin
				res[ch] = svm_pkg::SAT_MAX;
			end else if ($signed(acc) < -22'sd32768) begin
				res[ch] = svm_pkg::SAT_MIN;
			end else begin
				res[ch] = acc[svm_pkg::SMP_W-1:0];
			end
		end
		out_l = res[0];
		out_r = res[1];
	end

	// Output register
	logic [svm_pkg::SMP_W-1:0] out_l_q;
	logic [svm_pkg::SMP_W-1:0] out_r_q;
	logic                      active_q;
	logic                      ended_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (advance) begin
			out_l_q  <= out_l;
			out_r_q  <= out_r;
			active_q <= active_s1;
			ended_q  <= ended_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, ended_q, active_q, out_r_q, out_l_q};

endmodule
